// ----- hw/rtl/moa_pkg.sv -----
// ----------------------------------------------------------------------------
// moa_pkg
// Shared types, widths and codes of the multichannel oversampling averager.
// ----------------------------------------------------------------------------
package moa_pkg;

   localparam int CHANNELS   = 16;
   localparam int OVERSAMPLE = 16;
   localparam int FULL_SCALE = 4095;
   localparam int UV_PER_MV  = 1000;

   localparam int FUNC_W     = 3;
   localparam int CH_W       = 4;
   localparam int ADC_W      = 12;
   localparam int MV_W       = 16;
   localparam int UV_W       = 26;
   localparam int AGE_W      = 17;
   localparam int ACC_W      = 20;
   localparam int SCAN_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int PROD_W     = 28;   // 16 x 12 bit product
   localparam int DIV_W      = 38;   // product times 1000 plus rounding; even
   localparam int CH_AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam logic [FUNC_W-1:0] FUNC_SAMPLE  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_ERROR   = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_TICK    = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_READ    = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_CONVERT = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_VREFINT_CAL  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NOMINAL_MV   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VREF_CHANNEL = 2'd2;

   localparam logic [MV_W-1:0]  NOMINAL_MV_RESET = 16'd3300;
   localparam logic [MV_W-1:0]  MV_MAX           = 16'hFFFF;
   localparam logic [UV_W-1:0]  UV_MAX           = 26'h3FF_FFFF;
   localparam logic [ADC_W-1:0] ADC_MAX          = 12'hFFF;
   localparam logic [AGE_W-1:0] AGE_MAX          = 17'h1_FFFF;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [CH_W-1:0]   channel;
      logic [ADC_W-1:0]  value;
      logic              last_of_scan;
      logic [MV_W-1:0]   max_age_ms;
   } req_type;

   typedef struct packed {
      logic [ADC_W-1:0] avg_raw;
      logic [MV_W-1:0]  vdda_mv;
      logic [UV_W-1:0]  microvolts;
      logic             ready_res;
      logic             fresh;
   } rsp_type;

   typedef struct packed {
      logic [ADC_W-1:0] vrefint_cal;
      logic [MV_W-1:0]  nominal_vdda_mv;
      logic [CH_W-1:0]  vref_channel;
   } cfg_type;

endpackage

// ----- hw/rtl/multichannel_oversample_averager.sv -----
// ----------------------------------------------------------------------------
// multichannel_oversample_averager
// Per-channel oversampling averager with reference-based supply estimate.
// ----------------------------------------------------------------------------
//  channel  | ports                          | transfers
//  ---------+--------------------------------+-----------------------------------
//  request  | req_valid req_ready req_data   | sample, error, tick, read, convert
//  response | rsp_valid rsp_ready rsp_data   | one per read or convert
//  config   | csr_valid csr_ready csr_index  | register writes, always ready
//           | csr_data                       |
//
// Error and tick finish in the idle state, a sample adds an accumulator
// write; the sample closing the last scan adds a sweep of the accumulators.
// Read and convert use the shared divider for the supply estimate, skipped
// if a reference term is zero, and for microvolts, plus memory reads and multiplies.
// Reset clears control state and all memory valid bits; no clearing pass.
// A finished response waits in the output register while the next request
// is taken; the core holds a second response until that register frees.
// ----------------------------------------------------------------------------
module multichannel_oversample_averager (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  moa_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output moa_pkg::rsp_type                 rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [moa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [moa_pkg::CSR_DATA_W-1:0]   csr_data
);
   import moa_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   logic    out_free;
   logic    res_push;
   rsp_type res_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_VREFINT_CAL:  cfg_in.vrefint_cal     = csr_data[ADC_W-1:0];
            CSR_NOMINAL_MV:   cfg_in.nominal_vdda_mv = csr_data[MV_W-1:0];
            CSR_VREF_CHANNEL: cfg_in.vref_channel    = csr_data[CH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.vrefint_cal     <= '0;
         cfg_ff.nominal_vdda_mv <= NOMINAL_MV_RESET;
         cfg_ff.vref_channel    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // output register: free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_push) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   moa_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .out_free  (out_free),
      .res_push  (res_push),
      .res_data  (res_data)
   );

endmodule

// ----- hw/rtl/moa_div.sv -----
// ----------------------------------------------------------------------------
// moa_div
// Iterative restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module moa_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [moa_pkg::DIV_W-1:0]  dividend,
   input  logic [moa_pkg::ADC_W-1:0]  divisor,
   output logic                       busy,
   output logic                       done,
   output logic [moa_pkg::DIV_W-1:0]  quotient
);
   import moa_pkg::*;

   localparam int STEPS  = DIV_W / 2;
   localparam int STEP_W = $clog2(STEPS + 1);

   logic [DIV_W-1:0]  dq_ff;
   logic [DIV_W-1:0]  dq_in;
   logic [ADC_W-1:0]  rem_ff;
   logic [ADC_W-1:0]  rem_in;
   logic [ADC_W-1:0]  dvs_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic              done_ff;
   logic [ADC_W:0]    trial;

   // dividend bits shift out at the top, quotient bits shift in at the bottom
   always_comb begin
      rem_in = rem_ff;
      dq_in  = dq_ff;
      trial  = '0;
      for (int k = 0; k < 2; k++) begin
         trial = {rem_in, dq_in[DIV_W-1]};
         dq_in = {dq_in[DIV_W-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in   = ADC_W'(trial - {1'b0, dvs_ff});
            dq_in[0] = 1'b1;
         end else begin
            rem_in = trial[ADC_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            cnt_ff <= STEP_W'(STEPS);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == STEP_W'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dq_ff  <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (cnt_ff != '0) begin
         dq_ff  <= dq_in;
         rem_ff <= rem_in;
      end
   end

   assign busy     = (cnt_ff != '0);
   assign done     = done_ff;
   assign quotient = dq_ff;

endmodule

// ----- hw/rtl/moa_core.sv -----
// ----------------------------------------------------------------------------
// moa_core
// Sequencer around the accumulator and average memories, supply estimate
// and microvolt conversion through the shared divider.
// ----------------------------------------------------------------------------
module moa_core (
   input  logic              clock,
   input  logic              reset,
   input  moa_pkg::cfg_type  cfg,
   input  logic              req_valid,
   output logic              req_ready,
   input  moa_pkg::req_type  req_data,
   input  logic              out_free,
   output logic              res_push,
   output moa_pkg::rsp_type  res_data
);
   import moa_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_ACC_WR = 4'd1;
   localparam logic [3:0] S_SWEEP  = 4'd2;
   localparam logic [3:0] S_VREF   = 4'd3;
   localparam logic [3:0] S_MV_MUL = 4'd4;
   localparam logic [3:0] S_MV_DIV = 4'd5;
   localparam logic [3:0] S_RAW    = 4'd6;
   localparam logic [3:0] S_UV_MUL = 4'd7;
   localparam logic [3:0] S_UV_DIV = 4'd8;
   localparam logic [3:0] S_OUT    = 4'd9;

   localparam int SWP_W = $clog2(CHANNELS + 1);
   localparam logic [SWP_W-1:0]  SWP_LIMIT  = SWP_W'(CHANNELS);
   localparam logic [CH_W:0]     CH_LIMIT   = (CH_W + 1)'(CHANNELS);
   localparam logic [SCAN_W:0]   SCAN_LIMIT = (SCAN_W + 1)'(OVERSAMPLE);

   // control state
   logic [3:0]        state_ff, state_in;
   logic [SCAN_W-1:0] scan_ff, scan_in;
   logic              ready_ff, ready_in;
   logic [AGE_W-1:0]  age_ff, age_in;
   logic [SWP_W-1:0]  sweep_cnt_ff, sweep_cnt_in;
   logic              sweep_pend_ff, sweep_pend_in;

   // payload
   req_type           req_ff;
   logic [CH_AW-1:0]  sweep_idx_ff, sweep_idx_in;
   logic [ADC_W-1:0]  now_ff, now_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [MV_W-1:0]   mv_ff, mv_in;
   logic [ADC_W-1:0]  avg_out_ff, avg_out_in;
   logic [PROD_W-1:0] num_ff, num_in;
   logic [UV_W-1:0]   uv_ff, uv_in;

   // memories
   logic [ACC_W-1:0]    acc_mem [CHANNELS];
   logic [CHANNELS-1:0] acc_vld_ff;
   logic [ACC_W-1:0]    acc_rdata_ff;
   logic                acc_rvld_ff;
   logic                acc_rd_en, acc_wr_en, acc_clr_en;
   logic [CH_AW-1:0]    acc_rd_addr, acc_wr_addr, acc_clr_addr;
   logic [ACC_W-1:0]    acc_wr_data;

   logic [ADC_W-1:0]    avg_mem [CHANNELS];
   logic [CHANNELS-1:0] avg_vld_ff;
   logic [ADC_W-1:0]    avg_rdata_ff;
   logic                avg_rvld_ff;
   logic                avg_rd_en, avg_wr_en;
   logic [CH_AW-1:0]    avg_rd_addr, avg_wr_addr;
   logic [ADC_W-1:0]    avg_wr_data;

   // divider
   logic              div_start, div_busy, div_done;
   logic [DIV_W-1:0]  div_dividend, div_quot;
   logic [ADC_W-1:0]  div_divisor;

   // datapath terms
   logic              accept;
   logic              ch_ok_new, ch_ok, vref_ok;
   logic [ACC_W-1:0]  acc_eff, acc_quo;
   logic [ADC_W-1:0]  avg_clamp, now_eff, avg_sel, raw;
   logic [SCAN_W:0]   scan_next;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign ch_ok_new = ({1'b0, req_data.channel} < CH_LIMIT);
   assign ch_ok     = ({1'b0, req_ff.channel} < CH_LIMIT);
   assign vref_ok   = ({1'b0, cfg.vref_channel} < CH_LIMIT);

   assign acc_eff   = acc_rvld_ff ? acc_rdata_ff : '0;
   assign acc_quo   = acc_eff / ACC_W'(OVERSAMPLE);
   assign avg_clamp = (acc_quo > ACC_W'(ADC_MAX)) ? ADC_MAX : acc_quo[ADC_W-1:0];
   assign now_eff   = (vref_ok && avg_rvld_ff) ? avg_rdata_ff : '0;
   assign avg_sel   = (req_ff.func == FUNC_READ && ch_ok && avg_rvld_ff) ? avg_rdata_ff : '0;
   assign raw       = (req_ff.func == FUNC_READ) ? avg_sel : req_ff.value;
   assign scan_next = {1'b0, scan_ff} + 1'b1;

   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      ready_in      = ready_ff;
      age_in        = age_ff;
      sweep_cnt_in  = sweep_cnt_ff;
      sweep_pend_in = 1'b0;
      sweep_idx_in  = sweep_idx_ff;
      now_in        = now_ff;
      prod_in       = prod_ff;
      mv_in         = mv_ff;
      avg_out_in    = avg_out_ff;
      num_in        = num_ff;
      uv_in         = uv_ff;

      acc_rd_en    = 1'b0;
      acc_rd_addr  = req_ff.channel[CH_AW-1:0];
      acc_wr_en    = 1'b0;
      acc_wr_addr  = req_ff.channel[CH_AW-1:0];
      acc_wr_data  = acc_eff + ACC_W'(req_ff.value);
      acc_clr_en   = 1'b0;
      acc_clr_addr = sweep_idx_ff;
      avg_rd_en    = 1'b0;
      avg_rd_addr  = req_ff.channel[CH_AW-1:0];
      avg_wr_en    = 1'b0;
      avg_wr_addr  = sweep_idx_ff;
      avg_wr_data  = avg_clamp;

      div_start    = 1'b0;
      div_dividend = DIV_W'(prod_ff) + DIV_W'(now_ff >> 1);
      div_divisor  = now_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_data.func)
                  FUNC_SAMPLE: begin
                     acc_rd_en   = ch_ok_new;
                     acc_rd_addr = req_data.channel[CH_AW-1:0];
                     state_in    = S_ACC_WR;
                  end
                  FUNC_ERROR: begin
                     ready_in = 1'b0;
                  end
                  FUNC_TICK: begin
                     if (age_ff != AGE_MAX) begin
                        age_in = age_ff + 1'b1;
                     end
                  end
                  FUNC_READ, FUNC_CONVERT: begin
                     avg_rd_en   = 1'b1;
                     avg_rd_addr = cfg.vref_channel[CH_AW-1:0];
                     state_in    = S_VREF;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_ACC_WR: begin
            acc_wr_en = ch_ok;
            state_in  = S_IDLE;
            if (req_ff.last_of_scan) begin
               if (scan_next >= SCAN_LIMIT) begin
                  sweep_cnt_in = '0;
                  state_in     = S_SWEEP;
               end else begin
                  scan_in = scan_next[SCAN_W-1:0];
               end
            end
         end
         S_SWEEP: begin
            // read entry n while writing back entry n-1
            if (sweep_cnt_ff != SWP_LIMIT) begin
               acc_rd_en     = 1'b1;
               acc_rd_addr   = sweep_cnt_ff[CH_AW-1:0];
               sweep_pend_in = 1'b1;
               sweep_idx_in  = sweep_cnt_ff[CH_AW-1:0];
               sweep_cnt_in  = sweep_cnt_ff + 1'b1;
            end else begin
               scan_in  = '0;
               age_in   = '0;
               ready_in = 1'b1;
               state_in = S_IDLE;
            end
            if (sweep_pend_ff) begin
               avg_wr_en  = 1'b1;
               acc_clr_en = 1'b1;
            end
         end
         S_VREF: begin
            if (now_eff == '0 || cfg.vrefint_cal == '0) begin
               mv_in     = cfg.nominal_vdda_mv;
               avg_rd_en = 1'b1;
               state_in  = S_RAW;
            end else begin
               now_in   = now_eff;
               prod_in  = PROD_W'(cfg.nominal_vdda_mv) * PROD_W'(cfg.vrefint_cal);
               state_in = S_MV_MUL;
            end
         end
         S_MV_MUL: begin
            div_start = 1'b1;
            state_in  = S_MV_DIV;
         end
         S_MV_DIV: begin
            if (div_done) begin
               mv_in     = (div_quot > DIV_W'(MV_MAX)) ? MV_MAX : div_quot[MV_W-1:0];
               avg_rd_en = 1'b1;
               state_in  = S_RAW;
            end
         end
         S_RAW: begin
            avg_out_in = avg_sel;
            num_in     = PROD_W'(raw) * PROD_W'(mv_ff);
            state_in   = S_UV_MUL;
         end
         S_UV_MUL: begin
            // round to nearest: (raw * mv * 1000 + FULL_SCALE / 2) / FULL_SCALE
            div_start    = 1'b1;
            div_dividend = DIV_W'(num_ff) * DIV_W'(UV_PER_MV) + DIV_W'(FULL_SCALE / 2);
            div_divisor  = ADC_W'(FULL_SCALE);
            state_in     = S_UV_DIV;
         end
         S_UV_DIV: begin
            if (div_done) begin
               uv_in    = (div_quot > DIV_W'(UV_MAX)) ? UV_MAX : div_quot[UV_W-1:0];
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         scan_ff       <= '0;
         ready_ff      <= 1'b0;
         age_ff        <= '0;
         sweep_cnt_ff  <= '0;
         sweep_pend_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_ff       <= scan_in;
         ready_ff      <= ready_in;
         age_ff        <= age_in;
         sweep_cnt_ff  <= sweep_cnt_in;
         sweep_pend_ff <= sweep_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      sweep_idx_ff <= sweep_idx_in;
      now_ff       <= now_in;
      prod_ff      <= prod_in;
      mv_ff        <= mv_in;
      avg_out_ff   <= avg_out_in;
      num_ff       <= num_in;
      uv_ff        <= uv_in;
   end

   // accumulator memory, entries read as zero until written after reset or a sweep
   always_ff @(posedge clock) begin
      if (acc_wr_en) begin
         acc_mem[acc_wr_addr] <= acc_wr_data;
      end
      if (acc_rd_en) begin
         acc_rdata_ff <= acc_mem[acc_rd_addr];
         acc_rvld_ff  <= acc_vld_ff[acc_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_vld_ff <= '0;
      end else begin
         if (acc_wr_en) begin
            acc_vld_ff[acc_wr_addr] <= 1'b1;
         end
         if (acc_clr_en) begin
            acc_vld_ff[acc_clr_addr] <= 1'b0;
         end
      end
   end

   // average memory
   always_ff @(posedge clock) begin
      if (avg_wr_en) begin
         avg_mem[avg_wr_addr] <= avg_wr_data;
      end
      if (avg_rd_en) begin
         avg_rdata_ff <= avg_mem[avg_rd_addr];
         avg_rvld_ff  <= avg_vld_ff[avg_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_vld_ff <= '0;
      end else if (avg_wr_en) begin
         avg_vld_ff[avg_wr_addr] <= 1'b1;
      end
   end

   moa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign res_push            = (state_ff == S_OUT) && out_free;
   assign res_data.avg_raw    = avg_out_ff;
   assign res_data.vdda_mv    = mv_ff;
   assign res_data.microvolts = uv_ff;
   assign res_data.ready_res  = ready_ff;
   assign res_data.fresh      = ready_ff && (age_ff <= AGE_W'(req_ff.max_age_ms));

   assert property (@(posedge clock) disable iff (reset) div_start |-> !div_busy)
      else $error("divider started while busy");

   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_MV_DIV || state_ff == S_UV_DIV))
      else $error("divider finished outside a divide wait");

   assert property (@(posedge clock) disable iff (reset) {1'b0, scan_ff} < SCAN_LIMIT)
      else $error("scan count reached the oversample ratio");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWEEP && sweep_cnt_ff == SWP_LIMIT)
      |=> (ready_ff && age_ff == '0 && scan_ff == '0))
      else $error("sweep end did not restart averaging state");

   assert property (@(posedge clock) disable iff (reset)
      (acc_wr_en || acc_clr_en) |-> !(state_ff == S_VREF || state_ff == S_RAW))
      else $error("accumulator touched during a read or convert");

endmodule

// ----- tb/multichannel_oversample_averager_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_oversample_averager_tb
// Self-checking bench for the oversampling averager: a queue-fed request
// driver and a response monitor, with a built-in predictor of the channel
// sums, averages, age, ready flag and supply estimate.
// ----------------------------------------------------------------------------
module multichannel_oversample_averager_tb;
   import moa_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 100;
   localparam int HOLD_CYCLES    = 600;
   localparam int PHASE_ITEMS    = 230;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   multichannel_oversample_averager dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [ACC_W-1:0] sum_mem [CHANNELS];
   logic [ADC_W-1:0] mean_mem [CHANNELS];
   logic [SCAN_W-1:0] scans_done = '0;
   logic              means_valid = 1'b0;
   logic [AGE_W-1:0]  mean_age = '0;
   logic [ADC_W-1:0]  cal_reading = '0;
   logic [MV_W-1:0]   nominal_mv = NOMINAL_MV_RESET;
   logic [CH_W-1:0]   ref_ch = '0;

   req_type req_backlog [$];
   rsp_type due_readings [$];

   int  fault_count = 0;
   int  quiet_cycles = 0;
   int  readings_seen = 0;
   bit  tx_steady = 1'b0;
   int  tx_gap = 0;
   int  tx_calm = 0;
   bit  tx_free;
   int  rx_stall = 0;
   int  rx_calm = 0;
   int  rx_hold = 0;

   initial begin
      for (int i = 0; i < CHANNELS; i++) begin
         sum_mem[i]  = '0;
         mean_mem[i] = '0;
      end
   end

   function automatic int draw_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 85) return $urandom_range(1, 3);
      if (p < 97) return $urandom_range(4, 15);
      return $urandom_range(20, 120);
   endfunction

   function automatic logic [MV_W-1:0] supply_estimate();
      logic [63:0] now, cal, nom, v;
      now = '0;
      if (int'(ref_ch) < CHANNELS) now = 64'(mean_mem[ref_ch]);
      cal = 64'(cal_reading);
      nom = 64'(nominal_mv);
      if (now == 0 || cal == 0) return nominal_mv;
      v = (nom * cal + now / 2) / now;
      return (v > 64'(MV_MAX)) ? MV_MAX : v[MV_W-1:0];
   endfunction

   function automatic logic [UV_W-1:0] to_microvolts(input logic [ADC_W-1:0] raw,
                                                      input logic [MV_W-1:0] mv);
      logic [63:0] num, q, r, uv;
      num = 64'(raw) * 64'(mv);
      q   = num / FULL_SCALE;
      r   = num % FULL_SCALE;
      uv  = q * UV_PER_MV + (r * UV_PER_MV + FULL_SCALE / 2) / FULL_SCALE;
      return (uv > 64'(UV_MAX)) ? UV_MAX : uv[UV_W-1:0];
   endfunction

   // Advance the predicted state by one accepted request.
   function automatic void apply_request(input req_type r);
      rsp_type          out;
      logic [31:0]      quot;
      logic [ADC_W-1:0] mean;
      case (r.func)
         FUNC_SAMPLE: begin
            if (int'(r.channel) < CHANNELS)
               sum_mem[r.channel] = sum_mem[r.channel] + r.value;
            if (r.last_of_scan) begin
               if (int'(scans_done) + 1 >= OVERSAMPLE) begin
                  for (int i = 0; i < CHANNELS; i++) begin
                     quot = 32'(sum_mem[i]) / OVERSAMPLE;
                     mean_mem[i] = (quot > 32'(ADC_MAX)) ? ADC_MAX : quot[ADC_W-1:0];
                     sum_mem[i] = '0;
                  end
                  scans_done  = '0;
                  mean_age    = '0;
                  means_valid = 1'b1;
               end else begin
                  scans_done = scans_done + 1'b1;
               end
            end
         end
         FUNC_ERROR: means_valid = 1'b0;
         FUNC_TICK: begin
            if (mean_age < AGE_MAX) mean_age = mean_age + 1'b1;
         end
         FUNC_READ, FUNC_CONVERT: begin
            mean = '0;
            if (r.func == FUNC_READ && int'(r.channel) < CHANNELS) mean = mean_mem[r.channel];
            out.avg_raw    = mean;
            out.vdda_mv    = supply_estimate();
            out.microvolts = to_microvolts((r.func == FUNC_READ) ? mean : r.value,
                                           out.vdda_mv);
            out.ready_res  = means_valid;
            out.fresh      = means_valid && (mean_age <= AGE_W'(r.max_age_ms));
            due_readings.push_back(out);
         end
         default: ;
      endcase
   endfunction

   function automatic void check_reading(input rsp_type got);
      rsp_type want;
      if (due_readings.size() == 0) begin
         $error("response with nothing outstanding: %h", got);
         fault_count++;
         return;
      end
      want = due_readings.pop_front();
      if (got.avg_raw !== want.avg_raw) begin
         $error("avg_raw: expected %0d, got %0d", want.avg_raw, got.avg_raw);
         fault_count++;
      end
      if (got.vdda_mv !== want.vdda_mv) begin
         $error("vdda_mv: expected %0d, got %0d", want.vdda_mv, got.vdda_mv);
         fault_count++;
      end
      if (got.microvolts !== want.microvolts) begin
         $error("microvolts: expected %0d, got %0d", want.microvolts, got.microvolts);
         fault_count++;
      end
      if (got.ready_res !== want.ready_res) begin
         $error("ready_res: expected %0d, got %0d", want.ready_res, got.ready_res);
         fault_count++;
      end
      if (got.fresh !== want.fresh) begin
         $error("fresh: expected %0d, got %0d", want.fresh, got.fresh);
         fault_count++;
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         tx_free = !req_valid || req_ready;
         if (req_valid && req_ready) begin
            apply_request(req_data);
            if (tx_steady) begin
               tx_gap = 0;
            end else if (tx_calm > 0) begin
               tx_calm--;
               tx_gap = 0;
            end else if ($urandom_range(0, 49) == 0) begin
               tx_calm = $urandom_range(20, 80);
               tx_gap = 0;
            end else begin
               tx_gap = draw_gap();
            end
         end
         if (tx_free) begin
            if (tx_gap > 0) begin
               tx_gap--;
               req_valid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
               req_data  <= req_backlog.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_reading(rsp_data);
            readings_seen++;
            // hold off long enough for the block to back up into its input
            if (readings_seen == 100 || readings_seen == 300) begin
               rx_hold = HOLD_CYCLES;
            end else if (rx_calm > 0) begin
               rx_calm--;
            end else if ($urandom_range(0, 29) == 0) begin
               rx_calm = $urandom_range(10, 40);
            end else begin
               rx_stall = draw_gap();
            end
         end else if (rx_stall == 0 && rx_hold == 0 && rx_calm == 0 &&
                      $urandom_range(0, 15) == 0) begin
            rx_stall = draw_gap();
         end
         if (rx_hold > 0) begin
            rx_hold--;
            rsp_ready <= 1'b0;
         end else if (rx_stall > 0) begin
            rx_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("TEST FAILED");
      $finish;
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_VREFINT_CAL:  cal_reading = val[ADC_W-1:0];
         CSR_NOMINAL_MV:   nominal_mv  = val[MV_W-1:0];
         CSR_VREF_CHANNEL: ref_ch      = val[CH_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input int cal, input int nom, input int ch);
      write_reg(CSR_VREFINT_CAL, CSR_DATA_W'(cal));
      write_reg(CSR_NOMINAL_MV, CSR_DATA_W'(nom));
      write_reg(CSR_VREF_CHANNEL, CSR_DATA_W'(ch));
   endtask

   // Wait for every transfer to land, then let trailing sweeps finish.
   task automatic drain();
      while (req_backlog.size() != 0 || req_valid || due_readings.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic void push_item(input logic [FUNC_W-1:0] f, input int ch,
                                     input int v, input logic last, input int age_limit);
      req_type r;
      r.func         = f;
      r.channel      = CH_W'(ch);
      r.value        = ADC_W'(v);
      r.last_of_scan = last;
      r.max_age_ms   = MV_W'(age_limit);
      req_backlog.push_back(r);
   endfunction

   function automatic int rand_value();
      int p;
      p = $urandom_range(0, 9);
      if (p == 0) return 0;
      if (p == 1) return FULL_SCALE;
      if (p == 2) return $urandom_range(FULL_SCALE - 8, FULL_SCALE);
      return $urandom_range(0, FULL_SCALE);
   endfunction

   function automatic int rand_age_limit();
      int p;
      p = $urandom_range(0, 9);
      if (p == 0) return 0;
      if (p == 1) return 65535;
      if (p < 6) return $urandom_range(0, 30);
      return $urandom_range(0, 65535);
   endfunction

   function automatic void queue_traffic(input int target);
      int made, pick, k, ch;
      logic last;
      made = 0;
      while (made < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 52) begin
            // one scan of a few channels, usually closed by last_of_scan
            k = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : $urandom_range(4, 16);
            for (int j = 0; j < k; j++) begin
               ch = ($urandom_range(0, 2) == 0) ? int'(ref_ch) : $urandom_range(0, 15);
               last = (j == k - 1);
               if ($urandom_range(0, 19) == 0) last = !last;
               push_item(FUNC_SAMPLE, ch, rand_value(), last, $urandom_range(0, 65535));
            end
            made += k;
         end else if (pick < 55) begin
            // pile samples onto one channel so its average clamps
            k  = $urandom_range(17, 40);
            ch = $urandom_range(0, 15);
            for (int j = 0; j < k; j++)
               push_item(FUNC_SAMPLE, ch, $urandom_range(3000, FULL_SCALE), 1'b0,
                         $urandom_range(0, 65535));
            made += k;
         end else if (pick < 77) begin
            push_item(FUNC_READ, $urandom_range(0, 15), $urandom_range(0, 4095),
                      1'($urandom_range(0, 1)), rand_age_limit());
            made++;
         end else if (pick < 88) begin
            push_item(FUNC_CONVERT, $urandom_range(0, 15), rand_value(),
                      1'($urandom_range(0, 1)), rand_age_limit());
            made++;
         end else if (pick < 96) begin
            k = $urandom_range(1, 4);
            for (int j = 0; j < k; j++)
               push_item(FUNC_TICK, $urandom_range(0, 15), $urandom_range(0, 4095),
                         1'($urandom_range(0, 1)), $urandom_range(0, 65535));
            made += k;
         end else if (pick < 98) begin
            push_item(FUNC_ERROR, $urandom_range(0, 15), $urandom_range(0, 4095),
                      1'($urandom_range(0, 1)), $urandom_range(0, 65535));
            made++;
         end else begin
            push_item(FUNC_W'($urandom_range(5, 7)), $urandom_range(0, 15),
                      $urandom_range(0, 4095), 1'($urandom_range(0, 1)),
                      $urandom_range(0, 65535));
         end
      end
   endfunction

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed checks at the reset configuration
      set_config(0, NOMINAL_MV_RESET, 0);
      push_item(FUNC_READ, 0, FULL_SCALE, 1'b1, 65535);
      push_item(FUNC_CONVERT, 15, FULL_SCALE, 1'b0, 0);
      push_item(FUNC_CONVERT, 0, 0, 1'b1, 65535);
      push_item(3'd7, 15, FULL_SCALE, 1'b1, 65535);
      for (int i = 0; i < OVERSAMPLE; i++)
         push_item(FUNC_SAMPLE, i % CHANNELS, (i == 15) ? FULL_SCALE : i * 257, 1'b1, 0);
      push_item(FUNC_READ, 15, 0, 1'b0, 0);
      push_item(FUNC_TICK, 0, 0, 1'b0, 0);
      push_item(FUNC_READ, 15, 0, 1'b0, 0);
      push_item(FUNC_ERROR, 0, 0, 1'b0, 0);
      push_item(FUNC_READ, 1, 0, 1'b0, 65535);
      drain();

      set_config(1500, NOMINAL_MV_RESET, 0);
      queue_traffic(PHASE_ITEMS);
      drain();

      // extremes; also wrap one 20-bit sum
      set_config(FULL_SCALE, 65535, 15);
      for (int i = 0; i < 270; i++) push_item(FUNC_SAMPLE, 3, FULL_SCALE, 1'b0, 0);
      queue_traffic(PHASE_ITEMS - 270 > 60 ? PHASE_ITEMS - 270 : 60);
      drain();

      set_config(1, 0, 7);
      queue_traffic(PHASE_ITEMS);
      drain();

      repeat (3) begin
         set_config(($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, FULL_SCALE),
                    $urandom_range(0, 65535), $urandom_range(0, 15));
         queue_traffic(PHASE_ITEMS);
         drain();
      end

      // close an average, then age it to the fresh limit and past saturation
      set_config(1210, 3000, $urandom_range(0, 15));
      tx_steady = 1'b1;
      for (int i = 0; i < OVERSAMPLE; i++)
         push_item(FUNC_SAMPLE, $urandom_range(0, 15), rand_value(), 1'b1, 0);
      push_item(FUNC_READ, int'(ref_ch), 0, 1'b0, 0);
      repeat (65535) push_item(FUNC_TICK, 0, 0, 1'b0, 0);
      push_item(FUNC_READ, 0, 0, 1'b0, 65535);
      push_item(FUNC_TICK, 0, 0, 1'b0, 0);
      push_item(FUNC_READ, 0, 0, 1'b0, 65535);
      repeat (65546) push_item(FUNC_TICK, 0, 0, 1'b0, 0);
      push_item(FUNC_READ, 0, 0, 1'b0, 65535);
      push_item(FUNC_TICK, 0, 0, 1'b0, 0);
      push_item(FUNC_READ, int'(ref_ch), 0, 1'b0, 65535);
      push_item(FUNC_CONVERT, 0, FULL_SCALE, 1'b0, 65535);
      drain();
      tx_steady = 1'b0;

      if (fault_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
